@@ hdl/rpq_pkg.sv @@
// rpq_pkg: shared types, codes and constants of the ratio priority queue.
// Used by every module of the block but rpq_ram; depends on nothing.
`default_nettype none

package rpq_pkg;

    // Fixed field widths of the item format
    localparam int ID_WIDTH     = 16;
    localparam int DIV_WIDTH    = 16;
    localparam int STATUS_WIDTH = 3;
    localparam int DIV_CNT_W    = $clog2(DIV_WIDTH);

    // Defaults of the top-level parameters
    localparam int DEFAULT_DEPTH       = 16;
    localparam int DEFAULT_VALUE_WIDTH = 16;

    // Request kinds on the input side
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_DRAINED  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SEEK,
        S_SHIFT,
        S_PLACE,
        S_RESP,
        S_DRAIN_RD,
        S_DRAIN_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    accept;
        logic    div_step;
        logic    seek;
        logic    shift;
        logic    place;
        logic    drain_read;
        logic    drain_next;
        logic    emit;
        status_t emit_status;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_drain;
        logic divisor_zero;
        logic full;
        logic count_zero;
        logic div_last;
        logic shift_more;
        logic idx_one;
        logic drain_last;
        logic out_free;
    } stat_t;

endpackage : rpq_pkg

`default_nettype wire

@@ hdl/rpq_ram.sv @@
// rpq_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package needed.
`default_nettype none

module rpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : rpq_ram

`default_nettype wire

@@ hdl/rpq_ctrl.sv @@
// rpq_ctrl: sequencing state machine of the ratio priority queue.
// Depends on rpq_pkg for the state, command and status types.
`default_nettype none

module rpq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire rpq_pkg::stat_t stat,
    output rpq_pkg::cmd_t       cmd
);
    import rpq_pkg::*;

    state_t  state_reg, state_next;
    status_t resp_reg, resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_drain)
                begin
                    if (stat.count_zero)
                    begin
                        resp_next  = ST_EMPTY;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_DRAIN_RD;
                    end
                end
                else if (stat.divisor_zero)
                begin
                    resp_next  = ST_DIVZERO;
                    state_next = S_RESP;
                end
                else if (stat.full)
                begin
                    resp_next  = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_SEEK;
                end
            end
            S_SEEK:
            begin
                state_next = stat.count_zero ? S_PLACE : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!stat.shift_more || stat.idx_one)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                resp_next  = ST_INSERTED;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_EMIT;
            end
            S_DRAIN_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.drain_last ? S_IDLE : S_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.seek        = 1'b0;
        cmd.shift       = 1'b0;
        cmd.place       = 1'b0;
        cmd.drain_read  = 1'b0;
        cmd.drain_next  = 1'b0;
        cmd.emit        = 1'b0;
        cmd.emit_status = resp_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_SEEK:
            begin
                cmd.seek = !stat.count_zero;
            end
            S_SHIFT:
            begin
                cmd.shift = stat.shift_more;
            end
            S_PLACE:
            begin
                cmd.place = 1'b1;
            end
            S_RESP:
            begin
                cmd.emit = stat.out_free;
            end
            S_DRAIN_RD:
            begin
                cmd.drain_read = 1'b1;
            end
            S_DRAIN_EMIT:
            begin
                cmd.emit        = stat.out_free;
                cmd.drain_next  = stat.out_free;
                cmd.emit_status = ST_DRAINED;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule : rpq_ctrl

`default_nettype wire

@@ hdl/rpq_datapath.sv @@
// rpq_datapath: input latch, bit-serial divider, sorted entry table and result register.
// Depends on rpq_pkg and rpq_ram.
`default_nettype none

module rpq_datapath #(
    parameter int DEPTH       = rpq_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = rpq_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rpq_pkg::cmd_t                    cmd,
    output rpq_pkg::stat_t                        stat,
    input  wire logic                             in_action,
    input  wire logic [rpq_pkg::ID_WIDTH-1:0]     in_id,
    input  wire logic [rpq_pkg::DIV_WIDTH-1:0]    in_dividend,
    input  wire logic [rpq_pkg::DIV_WIDTH-1:0]    in_divisor,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output rpq_pkg::status_t                      out_status,
    output logic      [rpq_pkg::ID_WIDTH-1:0]     out_id,
    output logic      [rpq_pkg::DIV_WIDTH-1:0]    out_priority,
    output logic                                  out_last
);
    import rpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = VALUE_WIDTH + ID_WIDTH;

    // Latched request
    logic                 action_reg;
    logic [ID_WIDTH-1:0]  id_reg;
    logic [DIV_WIDTH-1:0] divisor_reg;

    // Divider
    logic [DIV_WIDTH-1:0] quo_reg, quo_next;
    logic [DIV_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_WIDTH:0]   rem_shift;
    logic [DIV_WIDTH:0]   rem_diff;
    logic                 rem_ge;

    // Table control
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] drain_reg;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_m2;
    logic [CW-1:0] drain_p1;

    // Priority of the pending insert
    logic [31:0]            quo_ext;
    logic [31:0]            limit_ext;
    logic [31:0]            pri_ext;
    logic [VALUE_WIDTH-1:0] pri_new;

    // RAM
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic [VALUE_WIDTH-1:0] rd_pri;
    logic [ID_WIDTH-1:0]    rd_id;
    logic [31:0]            rd_pri_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg  <= in_action;
            id_reg      <= in_id;
            divisor_reg <= in_divisor;
        end
    end

    // Restoring division, one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[DIV_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_comb
    begin
        quo_next = {quo_reg[DIV_WIDTH-2:0], rem_ge};
        rem_next = rem_ge ? rem_diff[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            quo_reg     <= in_dividend;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Saturate the quotient to the stored priority width
    assign quo_ext   = 32'(quo_reg);
    assign limit_ext = 32'({VALUE_WIDTH{1'b1}});
    assign pri_ext   = (quo_ext > limit_ext) ? limit_ext : quo_ext;
    assign pri_new   = pri_ext[VALUE_WIDTH-1:0];

    assign idx_m1   = idx_reg - CW'(1);
    assign idx_m2   = idx_reg - CW'(2);
    assign drain_p1 = drain_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.place)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.drain_next && (drain_p1 == count_reg))
        begin
            count_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg   <= count_reg;
            drain_reg <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                idx_reg <= idx_m1;
            end
            if (cmd.drain_next)
            begin
                drain_reg <= drain_p1;
            end
        end
    end

    // Move entries up one slot until the new priority fits, then write it
    always_comb
    begin
        wr_en   = cmd.shift || cmd.place;
        wr_addr = idx_reg[AW-1:0];
        wr_data = cmd.place ? {pri_new, id_reg} : rd_data;
        rd_en   = cmd.seek || cmd.shift || cmd.drain_read;
        if (cmd.seek)
        begin
            rd_addr = idx_m1[AW-1:0];
        end
        else if (cmd.shift)
        begin
            rd_addr = idx_m2[AW-1:0];
        end
        else
        begin
            rd_addr = drain_reg[AW-1:0];
        end
    end

    rpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_id      = rd_data[ID_WIDTH-1:0];
    assign rd_pri     = rd_data[EW-1:ID_WIDTH];
    assign rd_pri_ext = 32'(rd_pri);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status <= cmd.emit_status;
            if (cmd.emit_status == ST_DRAINED)
            begin
                out_id       <= rd_id;
                out_priority <= rd_pri_ext[DIV_WIDTH-1:0];
                out_last     <= (drain_p1 == count_reg);
            end
            else
            begin
                out_id       <= '0;
                out_priority <= '0;
                out_last     <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.is_drain     = (action_reg == ACT_DRAIN);
        stat.divisor_zero = (divisor_reg == '0);
        stat.full         = (count_reg == CW'(DEPTH));
        stat.count_zero   = (count_reg == '0);
        stat.div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_WIDTH - 1));
        stat.shift_more   = (rd_pri > pri_new);
        stat.idx_one      = (idx_reg == CW'(1));
        stat.drain_last   = (drain_p1 == count_reg);
        stat.out_free     = !out_valid || out_ready;
    end

endmodule : rpq_datapath

`default_nettype wire

@@ hdl/ratio_priority_queue.sv @@
// ratio_priority_queue: top level, a stable sorted priority queue keyed by a quotient.
// Depends on rpq_pkg, rpq_ctrl, rpq_datapath and rpq_ram.
//
// Usage:
//   Input items arrive on the s_ channel. s_tuser selects the request: insert or
//   drain. An insert carries an identifier, a dividend and a divisor; the block
//   divides, saturates the quotient to VALUE_WIDTH bits and files the entry in a
//   table of DEPTH entries kept in ascending priority, ties in arrival order.
//   Every insert answers with one item on the m_ channel: inserted, full or
//   divisor zero (the last two drop the request). A drain sends every stored
//   entry in order with status drained, tlast on the final one, and empties the
//   table; an empty table answers with a single empty status.
// Sequence:
//   One request at a time. An insert passes decode and a 16-step serial divider,
//   then shifts each stored entry of larger priority up one slot in the table
//   RAM, stopping at the first entry that is not larger, before it writes the
//   new entry and responds. A rejected insert or an empty drain goes from decode
//   straight to its response; a drain reads each entry from the RAM and then
//   emits it. A result sits in an output register, so a new request is taken
//   while the last result still waits.
// Reset and stall:
//   Reset empties the table and clears the output valid flag; table contents are
//   not cleared. When m_tready is low the block holds its result and waits.
`default_nettype none

module ratio_priority_queue #(
    parameter int DEPTH       = rpq_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = rpq_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item_id[15:0], dividend[31:16], divisor[47:32]
    input  wire logic        s_tuser,   // action[0]: 0 insert, 1 drain
    // Result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // out_id[15:0], out_priority[31:16]
    output logic      [2:0]  m_tuser,   // status[2:0]
    output logic             m_tlast
);
    import rpq_pkg::*;

    cmd_t                 cmd;
    stat_t                stat;
    status_t              out_status;
    logic [ID_WIDTH-1:0]  out_id;
    logic [DIV_WIDTH-1:0] out_priority;

    // Sequence the request through decode, divide, shift and respond, or through the drain
    rpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the request, the divider, the sorted table and the result register
    rpq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_action    (s_tuser),
        .in_id        (s_tdata[15:0]),
        .in_dividend  (s_tdata[31:16]),
        .in_divisor   (s_tdata[47:32]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .out_last     (m_tlast)
    );

    assign m_tdata = {out_priority, out_id};
    assign m_tuser = out_status;

endmodule : ratio_priority_queue

`default_nettype wire

@@ hdl/rpq_checker.sv @@
// rpq_checker: port-level assertions for ratio_priority_queue, bound to the top level.
// Depends on rpq_pkg for the status and request codes.
`default_nettype none

module rpq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import rpq_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // Status-only results carry no entry and close their request
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 3'(ST_DRAINED)) |-> (m_tdata == '0) && m_tlast)
        else $error("status result carries entry data or lacks tlast");

    // An accepted insert keeps the request side closed while it divides
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_INSERT) |=> ##1 !s_tready)
        else $error("request taken during an insert");

endmodule : rpq_checker

bind ratio_priority_queue rpq_checker u_rpq_checker (.*);

`default_nettype wire
